### rtl/assert_macros.svh
// Assertion macros used by the RTL of the propensity selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on the rising clock, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assertion that a condition never holds at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)
`endif

### rtl/tsps_pkg.sv
// Package with the types and constants of the two-state propensity selector.
`timescale 1ns / 1ps
package tsps_pkg;

  localparam int MAX_TRAPS = 256;
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int RATE_W    = 32;
  localparam int WGT_W     = 16;
  localparam int SHIFT_W   = 24;
  localparam int OUT_TOT_W = 40;
  localparam int TOT_W     = 41;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SELECT = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_CAPTURE  = 2'd1,
    KIND_EMISSION = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WRITE,
    ST_SEARCH,
    ST_WEIGHT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_SUM,
    ST_RESULT
  } state_e;

endpackage

### rtl/two_state_propensity_selector.sv
// Top level of the two-state propensity selector (Gillespie reaction selection).
`timescale 1ns / 1ps
// Usage: the input channel (in_valid_i / in_stall_o) carries one operation per
// transaction: clear the lists, write one trap's rates and weight, or select a
// reaction with a draw scaled to the total propensity. Each input transaction
// produces exactly one result transaction on out_valid_o / out_stall_i.
// The user must see that the trap_count register is written with trap_count_we_i
// only while the block is idle; the block itself does not enforce this. A clear or
// a write loads its result after a rescan of both lists that rebuilds the totals
// through the list and rate memories. A selection runs the prefix-sum search, a
// weight read, a read step and a write step per list entry moved to close the gap,
// an append step and then the same rescan; a draw that selects nothing and the
// no-op code go straight to the result state. One item is in work at a
// time, and the next is accepted the cycle after the result is loaded, even while
// that result still waits in the output register. After reset the neutral list
// holds every trap in order, the charged list is empty and all totals are zero.
// A stalled result holds its value, and the block waits before loading a new one.
module two_state_propensity_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        trap_count_we_i,
  input  logic [8:0]  trap_count_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  trap_index_i,
  input  logic [31:0] capture_rate_i,
  input  logic [31:0] emission_rate_i,
  input  logic [15:0] trap_weight_i,
  input  logic [39:0] draw_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  chosen_trap_o,
  output logic [1:0]  event_kind_o,
  output logic [8:0]  charged_count_o,
  output logic [23:0] threshold_shift_o,
  output logic [39:0] capture_total_o,
  output logic [39:0] emission_total_o
);

  localparam int N = tsps_pkg::MAX_TRAPS;
  localparam int IW = tsps_pkg::IDX_W;
  localparam int CW = tsps_pkg::CNT_W;
  localparam int TW = tsps_pkg::TOT_W;
  localparam logic [9:0] WALK_END = 10'(N + 2);
  localparam logic [CW-1:0] FULL = CW'(N);

  tsps_pkg::state_e state_q, state_d;

  // Memories.
  logic [IW-1:0]   nl_mem  [N];
  logic [IW-1:0]   cl_mem  [N];
  logic [31:0]     cap_mem [N];
  logic [31:0]     emi_mem [N];
  logic [15:0]     wgt_mem [N];
  logic [N-1:0]    nvalid_q;

  logic [IW-1:0]   nl_ra, cl_ra, nl_wa, cl_wa, nl_wd, cl_wd;
  logic            nl_we, cl_we, rate_we, wgt_re;
  logic [IW-1:0]   nl_rd_q, nl_ra_q, cl_rd_q;
  logic            nl_vld_q;
  logic [IW-1:0]   nl_val;
  logic [31:0]     cap_rd_q, emi_rd_q;
  logic [15:0]     wgt_rd_q;

  // Control and datapath registers.
  logic [CW-1:0]   trap_count_q, nc_q, tally_q;
  logic [23:0]     shift_q;
  logic [TW-1:0]   nt_q, ct_q, sum_n_q, sum_c_q, tgt_q;
  logic [IW-1:0]   idx_q, m_q, last_m_q, p2m_q, p1i_q, p2i_q;
  logic [CW-1:0]   pos_q, last_pos_q, j_q;
  logic [31:0]     cap_in_q, emi_in_q;
  logic [15:0]     wgt_in_q;
  logic            sel_c_q;
  tsps_pkg::kind_e kind_q, kind_d;
  logic [9:0]      k_q;
  logic            p1n_q, p1c_q, p2n_q, p2c_q;

  logic [7:0]      out_chosen_q;
  logic [1:0]      out_kind_q;
  logic [8:0]      out_count_q;
  logic [23:0]     out_shift_q;
  logic [39:0]     out_cap_q, out_emi_q;
  logic            out_valid_q;

  logic            accept, walk, hit, walk_done, res_load;
  logic [TW-1:0]   draw_ext, sel_sum, rate_ext;
  logic            cap_ev, emi_ev;
  logic [CW-1:0]   sel_cnt, nc_clear;
  logic [24:0]     shift_add;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != tsps_pkg::ST_IDLE);
  assign walk = (state_q == tsps_pkg::ST_SEARCH) || (state_q == tsps_pkg::ST_SUM);
  assign walk_done = (k_q == WALK_END);
  assign res_load = (state_q == tsps_pkg::ST_RESULT) && (!out_valid_q || !out_stall_i);

  assign nl_val = nl_vld_q ? nl_rd_q : nl_ra_q;
  assign draw_ext = {1'b0, draw_i};
  assign cap_ev = (draw_ext < nt_q) && (nc_q != '0);
  assign emi_ev = !cap_ev && (draw_ext >= nt_q) && ((draw_ext - nt_q) < ct_q)
                  && (tally_q != '0);
  assign sel_cnt = sel_c_q ? tally_q : nc_q;
  assign nc_clear = (trap_count_q > FULL) ? FULL : trap_count_q;
  assign rate_ext = sel_c_q ? {9'd0, emi_rd_q} : {9'd0, cap_rd_q};
  assign sel_sum = sum_n_q + rate_ext;
  assign hit = (state_q == tsps_pkg::ST_SEARCH) && (sel_c_q ? p2c_q : p2n_q)
               && (sel_sum >= tgt_q);
  assign shift_add = {1'b0, shift_q} + {9'd0, wgt_rd_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsps_pkg::ST_IDLE: begin
        if (accept) begin
          case (operation_i)
            tsps_pkg::OP_CLEAR:  state_d = tsps_pkg::ST_CLEAR;
            tsps_pkg::OP_WRITE:  state_d = tsps_pkg::ST_WRITE;
            tsps_pkg::OP_SELECT: state_d = (cap_ev || emi_ev) ? tsps_pkg::ST_SEARCH
                                                               : tsps_pkg::ST_RESULT;
            default:             state_d = tsps_pkg::ST_RESULT;
          endcase
        end
      end
      tsps_pkg::ST_CLEAR:  state_d = tsps_pkg::ST_SUM;
      tsps_pkg::ST_WRITE:  state_d = tsps_pkg::ST_SUM;
      tsps_pkg::ST_SEARCH: begin
        if (hit || walk_done) begin
          state_d = tsps_pkg::ST_WEIGHT;
        end
      end
      tsps_pkg::ST_WEIGHT: begin
        state_d = ((pos_q + 1'b1) < sel_cnt) ? tsps_pkg::ST_SHIFT_RD : tsps_pkg::ST_APPEND;
      end
      tsps_pkg::ST_SHIFT_RD: state_d = tsps_pkg::ST_SHIFT_WR;
      tsps_pkg::ST_SHIFT_WR: begin
        state_d = ((j_q + 2'd2) < {1'b0, sel_cnt}) ? tsps_pkg::ST_SHIFT_RD
                                                    : tsps_pkg::ST_APPEND;
      end
      tsps_pkg::ST_APPEND: state_d = tsps_pkg::ST_SUM;
      tsps_pkg::ST_SUM: begin
        if (walk_done) begin
          state_d = tsps_pkg::ST_RESULT;
        end
      end
      tsps_pkg::ST_RESULT: begin
        if (res_load) begin
          state_d = tsps_pkg::ST_IDLE;
        end
      end
      default: state_d = tsps_pkg::ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    nl_ra   = k_q[IW-1:0];
    cl_ra   = k_q[IW-1:0];
    nl_we   = 1'b0;
    cl_we   = 1'b0;
    nl_wa   = j_q[IW-1:0];
    cl_wa   = j_q[IW-1:0];
    nl_wd   = nl_val;
    cl_wd   = cl_rd_q;
    rate_we = 1'b0;
    wgt_re  = 1'b0;
    unique case (state_q)
      tsps_pkg::ST_WRITE:  rate_we = 1'b1;
      tsps_pkg::ST_WEIGHT: wgt_re = 1'b1;
      tsps_pkg::ST_SHIFT_RD: begin
        nl_ra = IW'(j_q + 1'b1);
        cl_ra = IW'(j_q + 1'b1);
      end
      tsps_pkg::ST_SHIFT_WR: begin
        nl_we = !sel_c_q;
        cl_we = sel_c_q;
      end
      tsps_pkg::ST_APPEND: begin
        nl_wa = nc_q[IW-1:0];
        cl_wa = tally_q[IW-1:0];
        nl_wd = m_q;
        cl_wd = m_q;
        nl_we = sel_c_q && (nc_q < FULL);
        cl_we = !sel_c_q && (tally_q < FULL);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      nl_mem[nl_wa] <= nl_wd;
    end
    nl_rd_q <= nl_mem[nl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cl_we) begin
      cl_mem[cl_wa] <= cl_wd;
    end
    cl_rd_q <= cl_mem[cl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rate_we) begin
      cap_mem[idx_q] <= cap_in_q;
    end
    cap_rd_q <= cap_mem[nl_val];
  end

  always_ff @(posedge clk_i) begin
    if (rate_we) begin
      emi_mem[idx_q] <= emi_in_q;
    end
    emi_rd_q <= emi_mem[cl_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (rate_we) begin
      wgt_mem[idx_q] <= wgt_in_q;
    end
    if (wgt_re) begin
      wgt_rd_q <= wgt_mem[m_q];
    end
  end

  // Kind of event decided at acceptance.
  always_comb begin
    kind_d = kind_q;
    if (accept) begin
      if (operation_i == tsps_pkg::OP_SELECT && cap_ev) begin
        kind_d = tsps_pkg::KIND_CAPTURE;
      end else if (operation_i == tsps_pkg::OP_SELECT && emi_ev) begin
        kind_d = tsps_pkg::KIND_EMISSION;
      end else begin
        kind_d = tsps_pkg::KIND_NONE;
      end
    end
  end

  // Payload registers of the current transaction and the walk pipeline.
  always_ff @(posedge clk_i) begin
    nl_ra_q  <= nl_ra;
    p1i_q    <= k_q[IW-1:0];
    p2i_q    <= p1i_q;
    p2m_q    <= sel_c_q ? cl_rd_q : nl_val;
    if (accept) begin
      idx_q    <= trap_index_i;
      cap_in_q <= capture_rate_i;
      emi_in_q <= emission_rate_i;
      wgt_in_q <= trap_weight_i;
      sel_c_q  <= !cap_ev;
      tgt_q    <= cap_ev ? draw_ext : (draw_ext - nt_q);
    end
    if (hit) begin
      m_q   <= p2m_q;
      pos_q <= {1'b0, p2i_q};
    end else if (state_q == tsps_pkg::ST_SEARCH && walk_done) begin
      // The search ran off the end: take the last listed entry.
      m_q   <= last_m_q;
      pos_q <= last_pos_q;
    end
    if (state_q == tsps_pkg::ST_SEARCH && (sel_c_q ? p2c_q : p2n_q)) begin
      last_m_q   <= p2m_q;
      last_pos_q <= {1'b0, p2i_q};
    end
    if (state_q == tsps_pkg::ST_WEIGHT) begin
      j_q <= pos_q;
    end else if (state_q == tsps_pkg::ST_SHIFT_WR) begin
      j_q <= j_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsps_pkg::ST_IDLE;
      trap_count_q <= FULL;
      nc_q         <= FULL;
      tally_q      <= '0;
      shift_q      <= '0;
      nt_q         <= '0;
      ct_q         <= '0;
      sum_n_q      <= '0;
      sum_c_q      <= '0;
      nvalid_q     <= '0;
      nl_vld_q     <= 1'b0;
      kind_q       <= tsps_pkg::KIND_NONE;
      k_q          <= '0;
      p1n_q        <= 1'b0;
      p1c_q        <= 1'b0;
      p2n_q        <= 1'b0;
      p2c_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      nl_vld_q <= nvalid_q[nl_ra];
      if (trap_count_we_i) begin
        trap_count_q <= trap_count_i;
      end
      if (nl_we) begin
        nvalid_q[nl_wa] <= 1'b1;
      end
      p1n_q <= walk && (k_q < {1'b0, nc_q});
      p1c_q <= walk && (k_q < {1'b0, tally_q});
      p2n_q <= p1n_q;
      p2c_q <= p1c_q;
      if (walk) begin
        k_q <= k_q + 1'b1;
      end else begin
        k_q <= '0;
      end
      unique case (state_q)
        tsps_pkg::ST_IDLE: begin
          // The prefix-sum search starts from zero.
          sum_n_q <= '0;
        end
        tsps_pkg::ST_CLEAR: begin
          nvalid_q <= '0;
          nc_q     <= nc_clear;
          tally_q  <= '0;
          shift_q  <= '0;
          sum_n_q  <= '0;
          sum_c_q  <= '0;
        end
        tsps_pkg::ST_WRITE: begin
          sum_n_q <= '0;
          sum_c_q <= '0;
        end
        tsps_pkg::ST_SEARCH: begin
          if (sel_c_q ? p2c_q : p2n_q) begin
            sum_n_q <= sel_sum;
          end
        end
        tsps_pkg::ST_APPEND: begin
          sum_n_q <= '0;
          sum_c_q <= '0;
          if (!sel_c_q) begin
            nc_q <= nc_q - 1'b1;
            if (tally_q < FULL) begin
              tally_q <= tally_q + 1'b1;
            end
            shift_q <= shift_add[24] ? '1 : shift_add[23:0];
          end else begin
            tally_q <= tally_q - 1'b1;
            if (nc_q < FULL) begin
              nc_q <= nc_q + 1'b1;
            end
            if (tally_q == CW'(1)) begin
              shift_q <= '0;
            end else if (shift_q > {8'd0, wgt_rd_q}) begin
              shift_q <= shift_q - {8'd0, wgt_rd_q};
            end else begin
              shift_q <= '0;
            end
          end
        end
        tsps_pkg::ST_SUM: begin
          if (p2n_q) begin
            sum_n_q <= sum_n_q + {9'd0, cap_rd_q};
          end
          if (p2c_q) begin
            sum_c_q <= sum_c_q + {9'd0, emi_rd_q};
          end
          if (walk_done) begin
            nt_q <= sum_n_q;
            ct_q <= sum_c_q;
          end
        end
        default: begin
        end
      endcase
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_chosen_q <= (kind_q == tsps_pkg::KIND_NONE) ? '0 : m_q;
      out_kind_q   <= kind_q;
      out_count_q  <= tally_q;
      out_shift_q  <= shift_q;
      out_cap_q    <= nt_q[TW-1] ? '1 : nt_q[39:0];
      out_emi_q    <= ct_q[TW-1] ? '1 : ct_q[39:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign chosen_trap_o     = out_chosen_q;
  assign event_kind_o      = out_kind_q;
  assign charged_count_o   = out_count_q;
  assign threshold_shift_o = out_shift_q;
  assign capture_total_o   = out_cap_q;
  assign emission_total_o  = out_emi_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_list_capacity, ({1'b0, nc_q} + {1'b0, tally_q}) <= 10'(N), "lists exceed capacity")
  `ASSERT_CLK(a_busy_after_accept, accept |=> in_stall_o, "block idle after a transaction")
  `ASSERT_CLK(a_empty_no_shift, (tally_q == '0) |-> (shift_q == '0), "shift with no charged trap")
  `ASSERT_CLK(a_result_held, (state_q == tsps_pkg::ST_RESULT && out_valid_q && out_stall_i) |=> $stable(out_kind_q), "stalled result overwritten")

endmodule
